// ===== hw/rtl/flti_pkg.sv =====
// shared request codes and result type for the flat tree index unit
package flti_pkg;

	localparam int PORT_WIDTH = 64;

	typedef enum logic [3:0] {
		REQ_DEPTH    = 4'd0,
		REQ_OFFSET   = 4'd1,
		REQ_PARENT   = 4'd2,
		REQ_SIBLING  = 4'd3,
		REQ_LCHILD   = 4'd4,
		REQ_RCHILD   = 4'd5,
		REQ_CHILDREN = 4'd6,
		REQ_SPANS    = 4'd7,
		REQ_LSPAN    = 4'd8,
		REQ_RSPAN    = 4'd9,
		REQ_COUNT    = 4'd10,
		REQ_ROOTS    = 4'd11
	} req_t;

	typedef struct packed {
		logic [PORT_WIDTH-1:0] value;
		logic [PORT_WIDTH-1:0] value_second;
		logic                  none;
		logic                  last;
	} result_t;

endpackage

// ===== hw/rtl/flti_calc.sv =====
// single-result node arithmetic: depth, offset, relatives, spans and count
module flti_calc #(
	parameter int INDEX_WIDTH = 64
) (
	input  flti_pkg::req_t    req,
	input  logic [INDEX_WIDTH-1:0] x,
	output flti_pkg::result_t res
);
	import flti_pkg::*;

	localparam int DW = $clog2(INDEX_WIDTH + 2);

	typedef logic [INDEX_WIDTH-1:0] idx_t;

	logic          leaf;
	logic [DW-1:0] d;
	logic [DW-1:0] d1;
	logic [DW-1:0] dm1;
	logic          all_ones;
	idx_t          off;
	idx_t          parent;
	idx_t          sibling;
	idx_t          lchild;
	idx_t          rchild;
	idx_t          lspan;
	idx_t          rspan;
	idx_t          count;

	// depth is the run of trailing ones
	always_comb begin
		d = DW'(INDEX_WIDTH);
		for (int i = INDEX_WIDTH - 1; i >= 0; i--) begin
			if (!x[i]) begin
				d = DW'(i);
			end
		end
	end

	assign leaf     = !x[0];
	assign d1       = d + DW'(1);
	assign dm1      = d - DW'(1);
	assign all_ones = (d == DW'(INDEX_WIDTH));
	assign off      = all_ones ? ({INDEX_WIDTH{1'b1}} >> 1) : (x >> d1);

	assign parent  = ((off | idx_t'(1)) << d1) - idx_t'(1);
	assign sibling = ((((off ^ idx_t'(1)) << 1) | idx_t'(1)) << d) - idx_t'(1);
	assign lchild  = (((off << 2) | idx_t'(1)) << dm1) - idx_t'(1);
	assign rchild  = (((off << 2) | idx_t'(3)) << dm1) - idx_t'(1);
	assign lspan   = off << d1;
	assign rspan   = ((off + idx_t'(1)) << d1) - idx_t'(2);
	assign count   = (idx_t'(1) << d1) - idx_t'(1);

	always_comb begin
		res.value        = '0;
		res.value_second = '0;
		res.none         = 1'b0;
		res.last         = 1'b1;
		case (req)
			REQ_DEPTH: begin
				res.value = PORT_WIDTH'(d);
			end
			REQ_OFFSET: begin
				res.value = PORT_WIDTH'(off);
			end
			REQ_PARENT: begin
				res.value = PORT_WIDTH'(parent);
			end
			REQ_SIBLING: begin
				res.value = PORT_WIDTH'(sibling);
			end
			REQ_LCHILD: begin
				res.none  = leaf;
				res.value = leaf ? '0 : PORT_WIDTH'(lchild);
			end
			REQ_RCHILD: begin
				res.none  = leaf;
				res.value = leaf ? '0 : PORT_WIDTH'(rchild);
			end
			REQ_CHILDREN: begin
				res.none         = leaf;
				res.value        = leaf ? '0 : PORT_WIDTH'(lchild);
				res.value_second = leaf ? '0 : PORT_WIDTH'(rchild);
			end
			REQ_SPANS: begin
				res.value        = PORT_WIDTH'(leaf ? x : lspan);
				res.value_second = PORT_WIDTH'(leaf ? x : rspan);
			end
			REQ_LSPAN: begin
				res.value = PORT_WIDTH'(leaf ? x : lspan);
			end
			REQ_RSPAN: begin
				res.value = PORT_WIDTH'(leaf ? x : rspan);
			end
			REQ_COUNT: begin
				res.value = PORT_WIDTH'(leaf ? idx_t'(1) : count);
			end
			default: begin
				// odd or zero full-roots index and unknown codes
				res.none = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/flti_roots.sv =====
// full-roots walker: one root per cycle, largest subtree first
module flti_roots #(
	parameter int INDEX_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [INDEX_WIDTH-2:0] leaves,
	output logic                   active,
	output flti_pkg::result_t      res
);
	import flti_pkg::*;

	localparam int FW = $clog2(INDEX_WIDTH - 1);

	typedef logic [INDEX_WIDTH-1:0] idx_t;

	logic [INDEX_WIDTH-2:0] rem_q;
	idx_t                   base_q;
	logic                   active_q;
	logic [FW-1:0]          fidx;
	logic [INDEX_WIDTH-2:0] f;
	logic [INDEX_WIDTH-2:0] rem_nx;
	idx_t                   base_nx;
	idx_t                   root;

	// highest remaining leaf-count bit
	always_comb begin
		fidx = '0;
		for (int i = 0; i < INDEX_WIDTH - 1; i++) begin
			if (rem_q[i]) begin
				fidx = FW'(i);
			end
		end
	end

	assign f       = {{(INDEX_WIDTH-2){1'b0}}, 1'b1} << fidx;
	assign rem_nx  = rem_q & ~f;
	assign root    = base_q + idx_t'(f) - idx_t'(1);
	assign base_nx = base_q + (idx_t'(f) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			base_q   <= '0;
			active_q <= 1'b0;
		end else if (load) begin
			rem_q    <= leaves;
			base_q   <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			rem_q  <= rem_nx;
			base_q <= base_nx;
			if (rem_nx == '0) begin
				active_q <= 1'b0;
			end
		end
	end

	assign active           = active_q;
	assign res.value        = PORT_WIDTH'(root);
	assign res.value_second = '0;
	assign res.none         = 1'b0;
	assign res.last         = (rem_nx == '0);

endmodule

// ===== hw/rtl/flat_tree_index_unit.sv =====
// top level of the flat tree index unit
// An item is taken when start is high and busy is low. Every request other
// than a full-roots request on an even nonzero index gives one result, shown
// on value, value_second, none and last for one cycle with strobe high, after
// it passes through the input register and then the result register. Such
// items can be issued every cycle while busy is low. A full-roots
// request on an even nonzero index gives one result per set bit of index/2,
// one per cycle from the root walker, and holds busy high until the cycle
// that the final root (last high) is registered; the next item can be taken
// in the cycle after. The receiver cannot stall the results.
module flat_tree_index_unit #(
	parameter int INDEX_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [3:0]                        req_type,
	input  logic [flti_pkg::PORT_WIDTH-1:0]   node_index,
	output logic                              strobe,
	output logic [flti_pkg::PORT_WIDTH-1:0]   value,
	output logic [flti_pkg::PORT_WIDTH-1:0]   value_second,
	output logic                              none,
	output logic                              last
);
	import flti_pkg::*;

	logic                   accept;
	logic                   roots_load;
	logic                   valid_s1;
	req_t                   req_s1;
	logic [INDEX_WIDTH-1:0] x_s1;
	logic                   roots_active;
	result_t                calc_res;
	result_t                roots_res;
	result_t                res_q;
	logic                   strobe_q;

	assign accept     = start && !busy;
	assign roots_load = accept && (req_t'(req_type) == REQ_ROOTS) && !node_index[0]
		&& (node_index[INDEX_WIDTH-1:0] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && !roots_load;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_t'(req_type);
			x_s1   <= node_index[INDEX_WIDTH-1:0];
		end
	end

	flti_calc #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_calc (
		.req (req_s1),
		.x   (x_s1),
		.res (calc_res)
	);

	flti_roots #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_roots (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (roots_load),
		.leaves (node_index[INDEX_WIDTH-1:1]),
		.active (roots_active),
		.res    (roots_res)
	);

	assign busy = roots_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= roots_active || valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (roots_active) begin
			res_q <= roots_res;
		end else if (valid_s1) begin
			res_q <= calc_res;
		end
	end

	assign strobe       = strobe_q;
	assign value        = res_q.value;
	assign value_second = res_q.value_second;
	assign none         = res_q.none;
	assign last         = res_q.last;

endmodule

// ===== hw/rtl/flti_checker.sv =====
// port-level checks for the flat tree index unit, bound to the top level
module flti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [3:0]  req_type,
	input logic        strobe,
	input logic [63:0] value,
	input logic [63:0] value_second,
	input logic        none,
	input logic        last
);
	import flti_pkg::*;

	// single-result items come out with strobe high after the input and result registers
	a_single_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_t'(req_type) != REQ_ROOTS) |-> ##2 strobe)
		else $error("single-result item not delivered on time");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && none) |-> (value == '0 && value_second == '0 && last))
		else $error("empty result carries data");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("root walk ended without a final item");

	a_mid_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final item outside a root walk");

endmodule

bind flat_tree_index_unit flti_checker u_flti_checker (.*);
